// ===== sv/md5_pkg.sv =====
// Shared types and constants for the MD5 stream hasher.
// Holds the round constant table, rotation amounts and message word order.
// No dependencies; imported by md5_stream_hasher.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] LAST_STEP = 7'd65;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_ADD  = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        MODE_DATA = 2'd0,
        MODE_PAD  = 2'd1,
        MODE_LEN  = 2'd2
    } mode_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            2'd3: g = 4'(7 * i[3:0]);
            default: g = i[3:0];
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        return (v << s) | (v >> (6'd32 - {1'b0, s}));
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== sv/md5_stream_hasher.sv =====
// Streaming MD5 hasher: byte intake, block buffer, and an iterative round unit.
// Depends on md5_pkg for the round tables, state and block mode types.
//
// Usage: the input channel (in_valid, in_ready, kind, data_byte) takes one beat per
// message byte when kind is 0 and a finish beat when kind is 1. The output channel
// (out_valid, out_ready, digest_front, digest_back) carries one beat per finish.
// A message byte is taken only while the hasher is idle. The byte that completes a
// 64-byte block starts a compression: after the message word and round constant are
// fetched into registers, one shared round unit runs the 64 rounds at one per cycle,
// then adds into the chaining words, and in_ready stays low until that is done. A
// finish beat runs one padded block, or two when fewer than 9 bytes of room remain
// in the block, and then loads the digest into the output register.
// The digest waits in its output register while the receiver stalls; message
// bytes are still taken meanwhile, and a later digest waits until the earlier one
// has gone. Reset returns the chaining words to the initial values, clears the
// byte count and drops out_valid; the block buffer needs no clearing.
module md5_stream_hasher
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_front,
    output logic [63:0] digest_back
);

    state_t       state_reg, state_next;
    mode_t        mode_reg, mode_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [60:0]  byte_count_reg, byte_count_next;
    logic [31:0]  chain_reg [4];
    logic [31:0]  chain_next [4];
    logic         out_valid_reg, out_valid_next;

    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  kw_reg;
    logic [31:0]  rdata_reg;
    logic [3:0]   g_reg;
    logic [63:0]  front_reg, back_reg;

    logic [31:0]  buf_mem [16];

    logic         in_fire;
    logic [5:0]   used;
    logic         used_short;
    logic [63:0]  len_bits;
    logic [3:0]   g_cur;
    logic [5:0]   kw_step;
    logic [5:0]   rnd;
    logic [31:0]  w_eff;
    logic [31:0]  f_val;
    logic [31:0]  sum_val;
    logic         round_en;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign used       = byte_count_reg[5:0];
    assign used_short = (used < LEN_START);
    assign len_bits   = {byte_count_reg, 3'b000};
    assign g_cur      = msg_index(cnt_reg[5:0]);
    assign kw_step    = 6'(cnt_reg - 7'd1);
    assign rnd        = 6'(cnt_reg - 7'd2);
    assign round_en   = (state_reg == S_RUN) && (cnt_reg >= 7'd2);

    assign out_valid    = out_valid_reg;
    assign digest_front = front_reg;
    assign digest_back  = back_reg;

    always_comb
    begin
        logic [5:0] pos;
        logic [7:0] len_byte;
        w_eff = rdata_reg;
        for (int lane = 0; lane < 4; lane++)
        begin
            pos      = {g_reg, 2'(lane)};
            len_byte = len_bits[8 * pos[2:0] +: 8];
            unique case (mode_reg)
                MODE_DATA:
                begin
                    w_eff[8 * lane +: 8] = rdata_reg[8 * lane +: 8];
                end
                MODE_PAD:
                begin
                    if (pos < used)
                    begin
                        w_eff[8 * lane +: 8] = rdata_reg[8 * lane +: 8];
                    end
                    else if (pos == used)
                    begin
                        w_eff[8 * lane +: 8] = PAD_BYTE;
                    end
                    else if (used_short && (pos >= LEN_START))
                    begin
                        w_eff[8 * lane +: 8] = len_byte;
                    end
                    else
                    begin
                        w_eff[8 * lane +: 8] = 8'h00;
                    end
                end
                MODE_LEN:
                begin
                    w_eff[8 * lane +: 8] = (pos >= LEN_START) ? len_byte : 8'h00;
                end
                default:
                begin
                    w_eff[8 * lane +: 8] = 8'h00;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (rnd[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            2'd3:    f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = 32'h0;
        endcase
        sum_val = a_reg + f_val + kw_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        byte_count_next = byte_count_reg;
        out_valid_next  = out_valid_reg;
        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!kind)
                    begin
                        byte_count_next = byte_count_reg + 61'd1;
                        if (used == LAST_SLOT)
                        begin
                            mode_next  = MODE_DATA;
                            cnt_next   = 7'd0;
                            state_next = S_RUN;
                        end
                    end
                    else
                    begin
                        mode_next  = MODE_PAD;
                        cnt_next   = 7'd0;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (mode_reg == MODE_DATA)
                begin
                    state_next = S_IDLE;
                end
                else if ((mode_reg == MODE_PAD) && !used_short)
                begin
                    mode_next  = MODE_LEN;
                    cnt_next   = 7'd0;
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    byte_count_next = 61'd0;
                    chain_next[0]   = IV_A;
                    chain_next[1]   = IV_B;
                    chain_next[2]   = IV_C;
                    chain_next[3]   = IV_D;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_DATA;
            cnt_reg        <= 7'd0;
            byte_count_reg <= 61'd0;
            out_valid_reg  <= 1'b0;
            chain_reg[0]   <= IV_A;
            chain_reg[1]   <= IV_B;
            chain_reg[2]   <= IV_C;
            chain_reg[3]   <= IV_D;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            cnt_reg        <= cnt_next;
            byte_count_reg <= byte_count_next;
            out_valid_reg  <= out_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !kind)
        begin
            buf_mem[used[5:2]][8 * used[1:0] +: 8] <= data_byte;
        end
        rdata_reg <= buf_mem[g_cur];
        g_reg     <= g_cur;
    end

    always_ff @(posedge clk)
    begin
        kw_reg <= round_const(kw_step) + w_eff;
        if ((state_reg == S_RUN) && (cnt_reg == 7'd0))
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (round_en)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rotl32(sum_val, rot_amount(rnd));
        end
        if ((state_reg == S_WAIT) && (!out_valid_reg || out_ready))
        begin
            front_reg <= {swap32(chain_reg[0]), swap32(chain_reg[1])};
            back_reg  <= {swap32(chain_reg[2]), swap32(chain_reg[3])};
        end
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_STEP)
        else $error("Round step counter ran past the last round.");

    a_finish_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && kind) |=> (state_reg == S_RUN) && (cnt_reg == 7'd0)
            && (mode_reg == MODE_PAD))
        else $error("A finish beat did not start the padded block.");

    a_len_block: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RUN) && (mode_reg == MODE_LEN)) |-> !used_short)
        else $error("Length-only block started although the length fit.");

    a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WAIT))
        else $error("Digest beat appeared outside the wait state.");

    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !kind && (used == LAST_SLOT)) |=> (state_reg == S_RUN)
            && (mode_reg == MODE_DATA) && (byte_count_reg[5:0] == 6'd0))
        else $error("A full block did not start a compression.");

endmodule
